FILE: rtl/delta_list_task_timer_queue_unit_assert.svh
// Assertion macros for the delta-list timer queue.
// Used by the top level only; the user provides i_clk and i_rst_n in scope.
`ifndef DELTA_LIST_TASK_TIMER_QUEUE_UNIT_ASSERT_SVH
`define DELTA_LIST_TASK_TIMER_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DLTTQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer queue check failed");

// Next-cycle implication, disabled during reset.
`define DLTTQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timer queue check failed");

`endif

FILE: rtl/dlttq_pkg.sv
// Shared types and constants of the delta-list timer queue.
// No dependencies; imported by the divider, datapath, controller and top level.
package dlttq_pkg;

    localparam int DW = 32;
    localparam int CW = $clog2(DW + 1);
    localparam int IDW = 8;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_DEL  = 2'd2;
    localparam logic [1:0] MODE_DISP = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    localparam logic [IDW-1:0] WAKE_MAX = 8'hFF;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RD_HEAD,
        OP_TICK,
        OP_FAIL,
        OP_FAIL_IDLE,
        OP_ADD_START,
        OP_ADD_ALLOC,
        OP_ADD_WRITE,
        OP_WALK_RD,
        OP_INS_STEP,
        OP_FIN1,
        OP_FIN2,
        OP_DEL_STEP,
        OP_DISP,
        OP_UNLINK0,
        OP_UNLINK1,
        OP_RELEASE,
        OP_REINSERT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic head_nil;
        logic free_nil;
        logic cur_nil;
        logic n_max;
        logic d_ge;
        logic id_match;
        logic wake_zero;
        logic per_zero;
        logic div_done;
        logic out_ready;
    } t_sts;

endpackage

FILE: rtl/delta_list_task_timer_queue_unit.sv
// Delta-list timer queue: up to MAX_TASKS timers in a delta-sorted linked list.
// Request channel: i_in_valid / o_in_stall with mode, delay, period, id, handle.
// Result channel: o_out_valid / i_out_stall with status, result id and handle.
// Every request yields exactly one result, in request order.
// The time from acceptance to result valid depends on the mode and the list walk
// (one memory read per entry over the shared port): a tick reads only the head,
// and nothing on an empty queue; a one-shot dispatch unlinks the head; a delete
// walks past every entry it skips; an add divides delay and period by the tick
// length with the reciprocal divider, then walks past every entry it passes; a
// periodic dispatch unlinks the head and reinserts it with such a walk.
// One request is worked at a time; o_in_stall is high from acceptance until
// the result enters the output register. A waiting result does not block the
// next request: the output register parts the two channels, and only a second
// result stalls the sequencer until the first is taken.
// Reset (synchronous, active low) empties the queue, links all slots into the
// free list, clears the id counter and the recycle stack, and drops any
// pending result. No clearing pass is needed after reset.
module delta_list_task_timer_queue_unit
    import dlttq_pkg::*;
#(
    parameter int MAX_TASKS     = 16,
    parameter int TICK_LENGTH   = 10,
    parameter int RECYCLE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_mode,
    input  logic [DW-1:0]  i_delay,
    input  logic [DW-1:0]  i_period,
    input  logic [IDW-1:0] i_task_id,
    input  logic [IDW-1:0] i_task_handle,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [1:0]     o_status,
    output logic [IDW-1:0] o_result_id,
    output logic [IDW-1:0] o_result_handle
);

`include "delta_list_task_timer_queue_unit_assert.svh"

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_idle;
    logic w_in_accept;

    // hold off new requests while one is in progress
    assign o_in_stall  = !w_idle;
    assign w_in_accept = i_in_valid && w_idle;

    dlttq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_mode    (i_mode),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_idle    (w_idle)
    );

    dlttq_dp #(
        .MAX_TASKS    (MAX_TASKS),
        .TICK_LENGTH  (TICK_LENGTH),
        .RECYCLE_DEPTH(RECYCLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_delay        (i_delay),
        .i_period       (i_period),
        .i_task_id      (i_task_id),
        .i_task_handle  (i_task_handle),
        .i_out_stall    (i_out_stall),
        .o_sts          (w_sts),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_result_id    (o_result_id),
        .o_result_handle(o_result_handle)
    );

    // an accepted request keeps the block busy in the following cycle
    `DLTTQ_ASSERT_NXT(a_busy_after_accept, w_in_accept, o_in_stall)
    // a new result never overwrites one the receiver has not taken
    `DLTTQ_ASSERT_IMP(a_no_result_overwrite, w_cmd.out_load, !o_out_valid || !i_out_stall)
    // a result is loaded only as the request finishes, never while idle
    `DLTTQ_ASSERT_NXT(a_load_ends_request, w_cmd.out_load, !o_in_stall && o_out_valid)

endmodule

FILE: rtl/dlttq_div.sv
// Divides two 32-bit values by the constant tick length with a reciprocal multiply.
// Depends on dlttq_pkg; one shared 32x32 multiplier, one operand per cycle.
module dlttq_div
    import dlttq_pkg::*;
#(
    parameter int DIVISOR = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_a,
    input  logic [DW-1:0] i_b,
    output logic [DW-1:0] o_qa,
    output logic [DW-1:0] o_qb,
    output logic          o_done
);

    // q = (x * ceil(2^(DW+L) / DIVISOR)) >> (DW+L) is exact for every DW-bit x
    localparam int L = $clog2(DIVISOR);
    localparam logic [63:0] MAGIC = ((64'd1 << (DW + L)) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [DW-1:0] M_LO = MAGIC[DW-1:0];
    localparam logic          M_HI = MAGIC[DW];

    logic [DW-1:0]   r_a, r_b, r_qa, r_qb;
    logic [1:0]      r_phase;
    logic            r_done;
    logic [DW-1:0]   w_x;
    logic [2*DW-1:0] w_lo;
    logic [2*DW:0]   w_prod;
    logic [DW-1:0]   w_q;

    // phase 1 works on the first operand, phase 2 on the second
    assign w_x    = (r_phase == 2'd1) ? r_a : r_b;
    assign w_lo   = {{DW{1'b0}}, w_x} * {{DW{1'b0}}, M_LO};
    assign w_prod = {1'b0, w_lo} + (M_HI ? {1'b0, w_x, {DW{1'b0}}} : '0);
    assign w_q    = DW'(w_prod >> (DW + L));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_done  <= 1'b0;
        end else if (i_start) begin
            r_phase <= 2'd1;
            r_done  <= 1'b0;
        end else if (r_phase == 2'd1) begin
            r_phase <= 2'd2;
        end else if (r_phase == 2'd2) begin
            r_phase <= 2'd0;
            r_done  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_phase == 2'd1) begin
            r_qa <= w_q;
        end
        if (r_phase == 2'd2) begin
            r_qb <= w_q;
        end
    end

    assign o_qa   = r_qa;
    assign o_qb   = r_qb;
    assign o_done = r_done;

endmodule

FILE: rtl/dlttq_dp.sv
// Datapath of the timer queue: entry memories, list pointers, id recycling,
// result and output registers. Depends on dlttq_pkg and dlttq_div.
module dlttq_dp
    import dlttq_pkg::*;
#(
    parameter int MAX_TASKS     = 16,
    parameter int TICK_LENGTH   = 10,
    parameter int RECYCLE_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cmd           i_cmd,
    input  logic [DW-1:0]  i_delay,
    input  logic [DW-1:0]  i_period,
    input  logic [IDW-1:0] i_task_id,
    input  logic [IDW-1:0] i_task_handle,
    input  logic           i_out_stall,
    output t_sts           o_sts,
    output logic           o_out_valid,
    output logic [1:0]     o_status,
    output logic [IDW-1:0] o_result_id,
    output logic [IDW-1:0] o_result_handle
);

    localparam int IW  = $clog2(MAX_TASKS);
    localparam int SW  = $clog2(MAX_TASKS + 1);
    localparam int RIW = (RECYCLE_DEPTH > 1) ? $clog2(RECYCLE_DEPTH) : 1;
    localparam int RTW = $clog2(RECYCLE_DEPTH + 1);
    localparam logic [SW-1:0]  NIL   = SW'(MAX_TASKS);
    localparam logic [RTW-1:0] RFULL = RTW'(RECYCLE_DEPTH);

    // entry memories
    logic [DW-1:0]  m_delta  [MAX_TASKS];
    logic [DW-1:0]  m_period [MAX_TASKS];
    logic [IDW-1:0] m_ident  [MAX_TASKS];
    logic [IDW-1:0] m_handle [MAX_TASKS];
    logic [IDW-1:0] m_wake   [MAX_TASKS];
    logic [SW-1:0]  m_link   [MAX_TASKS];
    logic [IDW-1:0] m_rec    [RECYCLE_DEPTH];
    logic [MAX_TASKS-1:0] r_lvalid;

    // registered read data
    logic [DW-1:0]  r_rd_delta, r_rd_period;
    logic [IDW-1:0] r_rd_ident, r_rd_handle, r_rd_wake, r_rec_rd;
    logic [SW-1:0]  r_rd_link;
    logic [IW-1:0]  r_rd_addr;
    logic           r_rd_lval;

    // pointers and working registers
    logic [SW-1:0]  r_head, r_free, r_slot, r_cur, r_prev, r_nxt, r_n;
    logic [IDW-1:0] r_seed, r_id, r_tid, r_handle;
    logic           r_use_rec, r_full;
    logic [RTW-1:0] r_rtop;
    logic [DW-1:0]  r_d, r_per, r_cdelta, r_delay, r_period;
    logic [1:0]     r_status, r_out_status;
    logic [IDW-1:0] r_rid, r_rhandle, r_out_id, r_out_handle;

    // memory ports
    logic           w_rd_en, w_rec_rd_en;
    logic [IW-1:0]  w_rd_addr;
    logic [RIW-1:0] w_rec_addr;
    logic           w_we_delta, w_we_wake, w_we_link, w_we_fields;
    logic [IW-1:0]  w_a_delta, w_a_wake, w_a_link;
    logic [DW-1:0]  w_d_delta;
    logic [IDW-1:0] w_d_wake, w_new_id;
    logic [SW-1:0]  w_d_link, w_rd_link;

    logic [DW-1:0]  w_q_del, w_q_per;
    logic           w_div_done;

    dlttq_div #(
        .DIVISOR(TICK_LENGTH)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.op == OP_ADD_START),
        .i_a    (r_delay),
        .i_b    (r_period),
        .o_qa   (w_q_del),
        .o_qb   (w_q_per),
        .o_done (w_div_done)
    );

    // an unwritten link reads as the free chain i -> i+1
    assign w_rd_link = r_rd_lval ? r_rd_link : (SW'(r_rd_addr) + SW'(1));
    assign w_new_id  = r_use_rec ? r_rec_rd : r_id;

    always_comb begin
        w_rd_en     = 1'b0;
        w_rd_addr   = r_cur[IW-1:0];
        w_rec_rd_en = 1'b0;
        w_rec_addr  = RIW'(r_rtop - RTW'(1));
        w_we_delta  = 1'b0;
        w_a_delta   = r_cur[IW-1:0];
        w_d_delta   = '0;
        w_we_wake   = 1'b0;
        w_a_wake    = r_head[IW-1:0];
        w_d_wake    = '0;
        w_we_link   = 1'b0;
        w_a_link    = r_slot[IW-1:0];
        w_d_link    = NIL;
        w_we_fields = 1'b0;
        unique case (i_cmd.op)
            OP_RD_HEAD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_head[IW-1:0];
            end
            OP_TICK: begin
                if (r_rd_delta == '0) begin
                    w_we_wake = (r_rd_wake != WAKE_MAX);
                    w_d_wake  = r_rd_wake + IDW'(1);
                end else begin
                    w_we_delta = 1'b1;
                    w_a_delta  = r_head[IW-1:0];
                    w_d_delta  = r_rd_delta - DW'(1);
                end
            end
            OP_ADD_START: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_free[IW-1:0];
            end
            OP_ADD_ALLOC: begin
                w_rec_rd_en = (r_rtop != '0);
            end
            OP_ADD_WRITE: begin
                w_we_fields = 1'b1;
                w_we_wake   = 1'b1;
                w_a_wake    = r_slot[IW-1:0];
                w_d_wake    = (w_q_del == '0) ? IDW'(1) : IDW'(0);
            end
            OP_WALK_RD: begin
                w_rd_en = 1'b1;
            end
            OP_FIN1: begin
                // take the remaining delta off the successor, link slot ahead of it
                w_we_delta = (r_cur < NIL);
                w_d_delta  = r_rd_delta - r_d;
                w_we_link  = 1'b1;
                w_d_link   = r_cur;
            end
            OP_FIN2: begin
                w_we_delta = 1'b1;
                w_a_delta  = r_slot[IW-1:0];
                w_d_delta  = r_d;
                w_we_link  = (r_prev < NIL);
                w_a_link   = r_prev[IW-1:0];
                w_d_link   = r_slot;
            end
            OP_DISP: begin
                w_we_wake = 1'b1;
                w_d_wake  = r_rd_wake - IDW'(1);
            end
            OP_UNLINK0: begin
                w_rd_en   = (w_rd_link < NIL);
                w_rd_addr = w_rd_link[IW-1:0];
            end
            OP_UNLINK1: begin
                // pass the removed delta on to the successor
                w_we_delta = (r_nxt < NIL);
                w_a_delta  = r_nxt[IW-1:0];
                w_d_delta  = r_rd_delta + r_cdelta;
                w_we_link  = (r_prev < NIL);
                w_a_link   = r_prev[IW-1:0];
                w_d_link   = r_nxt;
            end
            OP_RELEASE: begin
                w_we_link = 1'b1;
                w_a_link  = r_cur[IW-1:0];
                w_d_link  = r_free;
            end
            default: begin
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_we_delta) begin
            m_delta[w_a_delta] <= w_d_delta;
        end
        if (w_we_wake) begin
            m_wake[w_a_wake] <= w_d_wake;
        end
        if (w_we_link) begin
            m_link[w_a_link] <= w_d_link;
        end
        if (w_we_fields) begin
            m_ident[r_slot[IW-1:0]]  <= w_new_id;
            m_handle[r_slot[IW-1:0]] <= r_handle;
            m_period[r_slot[IW-1:0]] <= w_q_per;
        end
        if (i_cmd.op == OP_RELEASE && r_rtop < RFULL) begin
            m_rec[r_rtop[RIW-1:0]] <= r_rid;
        end
        if (w_rd_en) begin
            r_rd_delta  <= m_delta[w_rd_addr];
            r_rd_period <= m_period[w_rd_addr];
            r_rd_ident  <= m_ident[w_rd_addr];
            r_rd_handle <= m_handle[w_rd_addr];
            r_rd_wake   <= m_wake[w_rd_addr];
            r_rd_link   <= m_link[w_rd_addr];
            r_rd_lval   <= r_lvalid[w_rd_addr];
            r_rd_addr   <= w_rd_addr;
        end
        if (w_rec_rd_en) begin
            r_rec_rd <= m_rec[w_rec_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvalid <= '0;
            r_head   <= NIL;
            r_free   <= '0;
            r_seed   <= '0;
            r_rtop   <= '0;
            r_full   <= 1'b0;
        end else begin
            if (w_we_link) begin
                r_lvalid[w_a_link] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_full <= 1'b1;
            end else if (!i_out_stall) begin
                r_full <= 1'b0;
            end
            case (i_cmd.op)
                OP_ADD_ALLOC: begin
                    r_free <= w_rd_link;
                    if (r_rtop != '0) begin
                        r_rtop <= r_rtop - RTW'(1);
                    end else begin
                        r_seed <= r_seed + IDW'(1);
                    end
                end
                OP_FIN2: begin
                    if (!(r_prev < NIL)) begin
                        r_head <= r_slot;
                    end
                end
                OP_UNLINK1: begin
                    if (!(r_prev < NIL)) begin
                        r_head <= r_nxt;
                    end
                end
                OP_RELEASE: begin
                    r_free <= r_cur;
                    if (r_rtop < RFULL) begin
                        r_rtop <= r_rtop + RTW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_status;
            r_out_id     <= r_rid;
            r_out_handle <= r_rhandle;
        end
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_delay   <= i_delay;
                r_period  <= i_period;
                r_tid     <= i_task_id;
                r_handle  <= i_task_handle;
                r_status  <= ST_OK;
                r_rid     <= '0;
                r_rhandle <= '0;
                r_prev    <= NIL;
                r_cur     <= r_head;
                r_n       <= '0;
            end
            OP_FAIL:      r_status <= ST_FAIL;
            OP_FAIL_IDLE: r_status <= ST_NONE;
            OP_ADD_ALLOC: begin
                r_slot    <= r_free;
                r_use_rec <= (r_rtop != '0);
                r_id      <= r_seed;
            end
            OP_ADD_WRITE: begin
                r_rid     <= w_new_id;
                r_rhandle <= r_handle;
                r_d       <= w_q_del;
                r_prev    <= NIL;
                r_cur     <= r_head;
                r_n       <= '0;
            end
            OP_INS_STEP: begin
                r_d    <= r_d - r_rd_delta;
                r_prev <= r_cur;
                r_cur  <= w_rd_link;
                r_n    <= r_n + SW'(1);
            end
            OP_DEL_STEP: begin
                r_prev <= r_cur;
                r_cur  <= w_rd_link;
                r_n    <= r_n + SW'(1);
            end
            OP_DISP: begin
                r_rhandle <= r_rd_handle;
                r_per     <= r_rd_period;
                r_cur     <= r_head;
                r_prev    <= NIL;
            end
            OP_UNLINK0: begin
                r_rid    <= r_rd_ident;
                r_nxt    <= w_rd_link;
                r_cdelta <= r_rd_delta;
            end
            OP_REINSERT: begin
                r_slot <= r_cur;
                r_d    <= r_per;
                r_prev <= NIL;
                r_cur  <= r_head;
                r_n    <= '0;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.head_nil  = !(r_head < NIL);
    assign o_sts.free_nil  = !(r_free < NIL);
    assign o_sts.cur_nil   = !(r_cur < NIL);
    assign o_sts.n_max     = (r_n >= NIL);
    assign o_sts.d_ge      = (r_d >= r_rd_delta);
    assign o_sts.id_match  = (r_rd_ident == r_tid);
    assign o_sts.wake_zero = (r_rd_wake == '0);
    assign o_sts.per_zero  = (r_per == '0);
    assign o_sts.div_done  = w_div_done;
    assign o_sts.out_ready = !r_full || !i_out_stall;

    assign o_out_valid     = r_full;
    assign o_status        = r_out_status;
    assign o_result_id     = r_out_id;
    assign o_result_handle = r_out_handle;

endmodule

FILE: rtl/dlttq_ctrl.sv
// Controller of the timer queue: one-hot sequencer that issues datapath micro-ops.
// Depends on dlttq_pkg.
module dlttq_ctrl
    import dlttq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_idle
);

    typedef enum logic [18:0] {
        S_IDLE = 19'h00001,
        S_T0   = 19'h00002,
        S_T1   = 19'h00004,
        S_A0   = 19'h00008,
        S_ADIV = 19'h00010,
        S_A1   = 19'h00020,
        S_A2   = 19'h00040,
        S_IRD  = 19'h00080,
        S_IEV  = 19'h00100,
        S_FIN1 = 19'h00200,
        S_FIN2 = 19'h00400,
        S_DRD  = 19'h00800,
        S_DEV  = 19'h01000,
        S_P0   = 19'h02000,
        S_P1   = 19'h04000,
        S_U0   = 19'h08000,
        S_U1   = 19'h10000,
        S_U2   = 19'h20000,
        S_DONE = 19'h40000
    } t_state;

    t_state r_state, n_state;
    logic   r_disp, n_disp;

    always_comb begin
        n_state      = r_state;
        n_disp       = r_disp;
        o_cmd.op     = OP_NONE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_disp   = (i_mode == MODE_DISP);
                    unique case (i_mode)
                        MODE_TICK: n_state = S_T0;
                        MODE_ADD:  n_state = S_A0;
                        MODE_DEL:  n_state = S_DRD;
                        MODE_DISP: n_state = S_P0;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_T0: begin
                if (i_sts.head_nil) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_RD_HEAD;
                    n_state  = S_T1;
                end
            end
            S_T1: begin
                o_cmd.op = OP_TICK;
                n_state  = S_DONE;
            end
            S_A0: begin
                if (i_sts.free_nil) begin
                    o_cmd.op = OP_FAIL;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_ADD_START;
                    n_state  = S_ADIV;
                end
            end
            S_ADIV: begin
                if (i_sts.div_done) begin
                    n_state = S_A1;
                end
            end
            S_A1: begin
                o_cmd.op = OP_ADD_ALLOC;
                n_state  = S_A2;
            end
            S_A2: begin
                o_cmd.op = OP_ADD_WRITE;
                n_state  = S_IRD;
            end
            S_IRD: begin
                if (i_sts.cur_nil || i_sts.n_max) begin
                    n_state = S_FIN1;
                end else begin
                    o_cmd.op = OP_WALK_RD;
                    n_state  = S_IEV;
                end
            end
            S_IEV: begin
                // equal deltas are passed so the new entry lands after them
                if (i_sts.d_ge) begin
                    o_cmd.op = OP_INS_STEP;
                    n_state  = S_IRD;
                end else begin
                    n_state = S_FIN1;
                end
            end
            S_FIN1: begin
                o_cmd.op = OP_FIN1;
                n_state  = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.op = OP_FIN2;
                n_state  = S_DONE;
            end
            S_DRD: begin
                if (i_sts.cur_nil || i_sts.n_max) begin
                    o_cmd.op = OP_FAIL;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_WALK_RD;
                    n_state  = S_DEV;
                end
            end
            S_DEV: begin
                if (i_sts.id_match) begin
                    n_state = S_U0;
                end else begin
                    o_cmd.op = OP_DEL_STEP;
                    n_state  = S_DRD;
                end
            end
            S_P0: begin
                if (i_sts.head_nil) begin
                    o_cmd.op = OP_FAIL_IDLE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_RD_HEAD;
                    n_state  = S_P1;
                end
            end
            S_P1: begin
                if (i_sts.wake_zero) begin
                    o_cmd.op = OP_FAIL_IDLE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_DISP;
                    n_state  = S_U0;
                end
            end
            S_U0: begin
                o_cmd.op = OP_UNLINK0;
                n_state  = S_U1;
            end
            S_U1: begin
                o_cmd.op = OP_UNLINK1;
                n_state  = S_U2;
            end
            S_U2: begin
                if (r_disp && !i_sts.per_zero) begin
                    o_cmd.op = OP_REINSERT;
                    n_state  = S_IRD;
                end else begin
                    o_cmd.op = OP_RELEASE;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_disp  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_disp  <= n_disp;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule
